>>> rtl/core/record_stack_with_key_search_macros.svh
// Assertion macros shared by the record stack RTL.
// Included by the controller and datapath modules; no other dependencies.
`ifndef RECORD_STACK_WITH_KEY_SEARCH_MACROS_SVH
`define RECORD_STACK_WITH_KEY_SEARCH_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define RSKS_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("rsks assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define RSKS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("rsks assertion failed");

`endif

>>> rtl/core/rsks_pkg.sv
// Shared sizes, codes and controller/datapath interface types for the record stack.
// No dependencies.
`timescale 1ns / 1ps

package rsks_pkg;

	localparam int STACK_DEPTH = 16;
	localparam int ADDR_W      = $clog2(STACK_DEPTH);
	localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
	localparam int KEY_W       = 32;
	localparam int QTY_W       = 32;
	localparam int ST_W        = 2;
	localparam int CMD_W       = 3;
	localparam int RC_W        = 2;

	typedef enum logic [CMD_W-1:0] {
		CMD_PUSH   = 3'd0,
		CMD_POP    = 3'd1,
		CMD_TOP    = 3'd2,
		CMD_SEARCH = 3'd3,
		CMD_UPDATE = 3'd4
	} cmd_e_t;

	typedef enum logic [RC_W-1:0] {
		RC_OK       = 2'd0,
		RC_EMPTY    = 2'd1,
		RC_NOTFOUND = 2'd2,
		RC_FULL     = 2'd3
	} rc_t;

	typedef enum logic [1:0] {
		SEL_ZERO   = 2'd0,
		SEL_ECHO   = 2'd1,
		SEL_READ   = 2'd2,
		SEL_UPDATE = 2'd3
	} emit_sel_t;

	typedef struct packed {
		logic [KEY_W-1:0] key;
		logic [QTY_W-1:0] qty;
		logic [ST_W-1:0]  st;
	} rec_t;

	typedef struct packed {
		logic      load;
		logic      push_wr;
		logic      pop_dec;
		logic      rd_top;
		logic      rd_next;
		logic      upd_wr;
		logic      emit;
		emit_sel_t sel;
		rc_t       code;
	} dp_cmd_t;

	typedef struct packed {
		logic [CMD_W-1:0] command;
		logic             empty;
		logic             full;
		logic             match;
		logic             at_bottom;
	} dp_stat_t;

endpackage

>>> rtl/core/rsks_ctrl.sv
// Command sequencer for the record stack: dispatch, read wait and top-down key scan.
// Depends on rsks_pkg and record_stack_with_key_search_macros.svh.
`timescale 1ns / 1ps
`include "record_stack_with_key_search_macros.svh"

module rsks_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  rsks_pkg::dp_stat_t stat,
	output logic               busy,
	output rsks_pkg::dp_cmd_t  cmd
);

	typedef enum logic [3:0] {
		ST_IDLE     = 4'b0001,
		ST_DISPATCH = 4'b0010,
		ST_FETCH    = 4'b0100,
		ST_SCAN     = 4'b1000
	} state_t;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy = (state_q != ST_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d  = ST_DISPATCH;
				end
			end
			ST_DISPATCH: begin
				state_d = ST_IDLE;
				unique case (stat.command) inside
					rsks_pkg::CMD_PUSH: begin
						cmd.emit = 1'b1;
						if (stat.full) begin
							cmd.sel  = rsks_pkg::SEL_ZERO;
							cmd.code = rsks_pkg::RC_FULL;
						end else begin
							cmd.push_wr = 1'b1;
							cmd.sel     = rsks_pkg::SEL_ECHO;
							cmd.code    = rsks_pkg::RC_OK;
						end
					end
					rsks_pkg::CMD_POP, rsks_pkg::CMD_TOP: begin
						if (stat.empty) begin
							cmd.emit = 1'b1;
							cmd.sel  = rsks_pkg::SEL_ZERO;
							cmd.code = rsks_pkg::RC_EMPTY;
						end else begin
							cmd.rd_top  = 1'b1;
							cmd.pop_dec = (stat.command == rsks_pkg::CMD_POP);
							state_d     = ST_FETCH;
						end
					end
					rsks_pkg::CMD_SEARCH, rsks_pkg::CMD_UPDATE: begin
						if (stat.empty) begin
							cmd.emit = 1'b1;
							cmd.sel  = rsks_pkg::SEL_ZERO;
							cmd.code = rsks_pkg::RC_NOTFOUND;
						end else begin
							cmd.rd_top = 1'b1;
							state_d    = ST_SCAN;
						end
					end
					default: begin
						cmd.emit = 1'b1;
						cmd.sel  = rsks_pkg::SEL_ZERO;
						cmd.code = rsks_pkg::RC_OK;
					end
				endcase
			end
			ST_FETCH: begin
				cmd.emit = 1'b1;
				cmd.sel  = rsks_pkg::SEL_READ;
				cmd.code = rsks_pkg::RC_OK;
				state_d  = ST_IDLE;
			end
			ST_SCAN: begin
				if (stat.match) begin
					cmd.emit = 1'b1;
					cmd.code = rsks_pkg::RC_OK;
					if (stat.command == rsks_pkg::CMD_UPDATE) begin
						cmd.upd_wr = 1'b1;
						cmd.sel    = rsks_pkg::SEL_UPDATE;
					end else begin
						cmd.sel = rsks_pkg::SEL_READ;
					end
					state_d = ST_IDLE;
				end else if (stat.at_bottom) begin
					cmd.emit = 1'b1;
					cmd.sel  = rsks_pkg::SEL_ZERO;
					cmd.code = rsks_pkg::RC_NOTFOUND;
					state_d  = ST_IDLE;
				end else begin
					cmd.rd_next = 1'b1;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	`RSKS_ASSERT_NEXT(a_accept_dispatch, clk, arst_n, start && !busy, state_q == ST_DISPATCH)
	`RSKS_ASSERT_NEXT(a_emit_idle, clk, arst_n, cmd.emit, state_q == ST_IDLE)
	`RSKS_ASSERT_SAME(a_fetch_emits, clk, arst_n, state_q == ST_FETCH, cmd.emit)

endmodule

>>> rtl/core/rsks_dpath.sv
// Record memory, entry count, scan pointer, key compare and result registers.
// Depends on rsks_pkg and record_stack_with_key_search_macros.svh.
`timescale 1ns / 1ps
`include "record_stack_with_key_search_macros.svh"

module rsks_dpath (
	input  logic                                clk,
	input  logic                                arst_n,
	input  rsks_pkg::dp_cmd_t                   cmd,
	output rsks_pkg::dp_stat_t                  stat,
	input  logic [rsks_pkg::CMD_W-1:0]          command,
	input  logic signed [rsks_pkg::KEY_W-1:0]   order_key,
	input  logic signed [rsks_pkg::QTY_W-1:0]   item_quantity,
	input  logic [rsks_pkg::ST_W-1:0]           status_code,
	output logic                                done,
	output logic [rsks_pkg::RC_W-1:0]           result_code,
	output logic signed [rsks_pkg::KEY_W-1:0]   found_key,
	output logic signed [rsks_pkg::QTY_W-1:0]   found_quantity,
	output logic [rsks_pkg::ST_W-1:0]           found_status
);

	logic [rsks_pkg::CMD_W-1:0]  cmd_q;
	logic [rsks_pkg::KEY_W-1:0]  key_q;
	logic [rsks_pkg::QTY_W-1:0]  qty_q;
	logic [rsks_pkg::ST_W-1:0]   st_q;
	logic [rsks_pkg::CNT_W-1:0]  count_q;
	logic [rsks_pkg::ADDR_W-1:0] cur_q;
	logic                        done_q;
	rsks_pkg::rec_t              mem_q [rsks_pkg::STACK_DEPTH];
	rsks_pkg::rec_t              rd_data_q;
	rsks_pkg::rec_t              wr_rec;
	logic [rsks_pkg::ADDR_W-1:0] wr_addr;
	logic [rsks_pkg::ADDR_W-1:0] rd_addr;
	logic [rsks_pkg::ADDR_W-1:0] top_addr;
	logic                        wr_en;
	logic                        rd_en;
	logic [rsks_pkg::RC_W-1:0]   rc_q;
	logic [rsks_pkg::KEY_W-1:0]  out_key_q;
	logic [rsks_pkg::QTY_W-1:0]  out_qty_q;
	logic [rsks_pkg::ST_W-1:0]   out_st_q;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			cmd_q <= command;
			key_q <= order_key;
			qty_q <= item_quantity;
			st_q  <= status_code;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.push_wr) begin
			count_q <= count_q + rsks_pkg::CNT_W'(1);
		end else if (cmd.pop_dec) begin
			count_q <= count_q - rsks_pkg::CNT_W'(1);
		end
	end

	assign top_addr = rsks_pkg::ADDR_W'(count_q - rsks_pkg::CNT_W'(1));
	assign rd_en    = cmd.rd_top || cmd.rd_next;
	assign rd_addr  = cmd.rd_top ? top_addr : (cur_q - rsks_pkg::ADDR_W'(1));
	assign wr_en    = cmd.push_wr || cmd.upd_wr;
	assign wr_addr  = cmd.push_wr ? count_q[rsks_pkg::ADDR_W-1:0] : cur_q;

	always_comb begin
		if (cmd.push_wr) begin
			wr_rec = '{key: key_q, qty: qty_q, st: st_q};
		end else begin
			wr_rec = '{key: rd_data_q.key, qty: rd_data_q.qty, st: st_q};
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_rec;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
			cur_q     <= rd_addr;
		end
	end

	assign stat.command   = cmd_q;
	assign stat.empty     = (count_q == '0);
	assign stat.full      = (count_q == rsks_pkg::CNT_W'(rsks_pkg::STACK_DEPTH));
	assign stat.match     = (rd_data_q.key == key_q);
	assign stat.at_bottom = (cur_q == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= cmd.emit;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			rc_q <= cmd.code;
			case (cmd.sel)
				rsks_pkg::SEL_ECHO: begin
					out_key_q <= key_q;
					out_qty_q <= qty_q;
					out_st_q  <= st_q;
				end
				rsks_pkg::SEL_READ: begin
					out_key_q <= rd_data_q.key;
					out_qty_q <= rd_data_q.qty;
					out_st_q  <= rd_data_q.st;
				end
				rsks_pkg::SEL_UPDATE: begin
					out_key_q <= rd_data_q.key;
					out_qty_q <= rd_data_q.qty;
					out_st_q  <= st_q;
				end
				default: begin
					out_key_q <= '0;
					out_qty_q <= '0;
					out_st_q  <= '0;
				end
			endcase
		end
	end

	assign done           = done_q;
	assign result_code    = rc_q;
	assign found_key      = out_key_q;
	assign found_quantity = out_qty_q;
	assign found_status   = out_st_q;

	`RSKS_ASSERT_SAME(a_count_bound, clk, arst_n, 1'b1, count_q <= rsks_pkg::CNT_W'(rsks_pkg::STACK_DEPTH))
	`RSKS_ASSERT_SAME(a_push_room, clk, arst_n, cmd.push_wr, !stat.full && !cmd.pop_dec)
	`RSKS_ASSERT_NEXT(a_pop_shrinks, clk, arst_n, cmd.pop_dec, count_q == $past(count_q) - rsks_pkg::CNT_W'(1))

endmodule

>>> rtl/core/record_stack_with_key_search.sv
// Channel   Handshake          Ports
// command   start / busy       command, order_key, item_quantity, status_code
// result    done (one cycle)   result_code, found_key, found_quantity, found_status
//
// Push, unused codes and empty/full cases: done follows the dispatch state, which emits the result.
// Pop and top: dispatch reads the top record, then the fetch state emits it; one read of the record memory port.
// Search and update: the scan starts at the top record and moves down to the newest match, one record
// compared per cycle through the single memory read port; a miss scans down to the bottom entry.
// Reset clears the entry count and controller; records need no clearing.
// The receiver cannot stall: done marks each result once; the result registers hold it until the next result.
// Depends on rsks_pkg, rsks_ctrl and rsks_dpath.
`timescale 1ns / 1ps

module record_stack_with_key_search (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  logic [rsks_pkg::CMD_W-1:0]        command,
	input  logic signed [rsks_pkg::KEY_W-1:0] order_key,
	input  logic signed [rsks_pkg::QTY_W-1:0] item_quantity,
	input  logic [rsks_pkg::ST_W-1:0]         status_code,
	output logic                              done,
	output logic [rsks_pkg::RC_W-1:0]         result_code,
	output logic signed [rsks_pkg::KEY_W-1:0] found_key,
	output logic signed [rsks_pkg::QTY_W-1:0] found_quantity,
	output logic [rsks_pkg::ST_W-1:0]         found_status
);

	rsks_pkg::dp_cmd_t  dp_cmd;
	rsks_pkg::dp_stat_t dp_stat;

	rsks_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (dp_stat),
		.busy   (busy),
		.cmd    (dp_cmd)
	);

	rsks_dpath u_dpath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (dp_cmd),
		.stat           (dp_stat),
		.command        (command),
		.order_key      (order_key),
		.item_quantity  (item_quantity),
		.status_code    (status_code),
		.done           (done),
		.result_code    (result_code),
		.found_key      (found_key),
		.found_quantity (found_quantity),
		.found_status   (found_status)
	);

endmodule
